>>> src/tscr_pkg.sv
`timescale 1ns / 1ps
package tscr_pkg;

    // Geometry of the store
    localparam int SLOT_COUNT   = 9;
    localparam int PACKET_WORDS = 47;

    localparam int WORD_W      = 32;
    localparam int WORD_CNT_W  = $clog2(PACKET_WORDS + 1);
    localparam int STG_ADDR_W  = $clog2(PACKET_WORDS);
    localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_SEL_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_DEPTH  = SLOT_COUNT * PACKET_WORDS;
    localparam int SLOT_ADDR_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    localparam logic [SLOT_IDX_W-1:0] NEW_SLOT = SLOT_IDX_W'(SLOT_COUNT);

    // Result field widths
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 6;
    localparam int INFO_W    = 8;
    localparam int SRC_W     = 4;
    localparam int M_TDATA_W = 56;
    localparam int APB_ADDR_W = 3;

    // Control packet header and table ids
    localparam logic [23:0] CTRL_SYNC = 24'h474003;
    localparam logic [7:0]  ID_CLEAR  = 8'd0;
    localparam logic [7:0]  ID_FIRST  = 8'd150;
    localparam logic [7:0]  ID_END    = 8'd159;

    // Input selector codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Register index (paddr bit 2)
    localparam logic REG_OUTPUT_ENABLE = 1'b0;
    localparam logic REG_REPLAY_ENABLE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REFUSED  = 2'd1,
        KIND_DATA     = 2'd2,
        KIND_IDLE     = 2'd3
    } kind_t;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    // Lowest valid slot at or above start, NEW_SLOT if none
    function automatic slot_idx_t first_valid(input logic [SLOT_COUNT-1:0] valid,
                                              input slot_idx_t start);
        slot_idx_t res;
        res = NEW_SLOT;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (valid[s] && (SLOT_IDX_W'(s) >= start)) begin
                res = SLOT_IDX_W'(s);
            end
        end
        return res;
    endfunction

    // First store address of a slot
    function automatic logic [SLOT_ADDR_W-1:0] slot_base(input slot_idx_t slot);
        return SLOT_ADDR_W'(32'(slot) * PACKET_WORDS);
    endfunction

endpackage

>>> src/tscr_ram.sv
`timescale 1ns / 1ps
module tscr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ts_control_packet_capture_replay.sv
`timescale 1ns / 1ps
// A result passes from the held result registers into the output register, which waits while the output is stalled.
// No new item is taken until the last result has moved on; each item makes at most one read or write of a word memory.
// The last load of a captured control packet adds a copy from the staging
// memory into the slot memory (one word per cycle through its single read port).
// Reset (aresetn low, synchronous) clears control state; memories are not cleared.
module ts_control_packet_capture_replay (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] packet_word
    input  logic        s_tuser,   // [0] operation
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [tscr_pkg::M_TDATA_W-1:0] m_tdata, // [31:0] data_word, [37:32] word_index,
                                                    // [45:38] info_byte, [46] burst_end,
                                                    // [50:47] source_slot, [55:51] zero
    output logic [tscr_pkg::KIND_W-1:0]    m_tuser, // [1:0] kind
    output logic        m_tlast,   // packet_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tscr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import tscr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_COPY
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic output_enable_reg, output_enable_next;
    logic replay_enable_reg, replay_enable_next;

    // load side
    logic [WORD_CNT_W-1:0] load_count_reg, load_count_next;
    logic [23:0]           hdr_reg, hdr_next;
    logic [7:0]            id_reg, id_next;
    logic [INFO_W-1:0]     staging_info_reg, staging_info_next;
    logic [SLOT_COUNT-1:0] slot_valid_reg, slot_valid_next;
    logic [INFO_W-1:0]     slot_info_reg [SLOT_COUNT];
    logic [INFO_W-1:0]     slot_info_next [SLOT_COUNT];

    // replay side
    logic                  replay_pending_reg, replay_pending_next;
    slot_idx_t             replay_slot_reg, replay_slot_next;
    logic [INDEX_W-1:0]    replay_word_reg, replay_word_next;

    // copy sequencer
    logic                   copy_needed_reg, copy_needed_next;
    logic [SLOT_ADDR_W-1:0] copy_base_reg, copy_base_next;
    logic [WORD_CNT_W-1:0]  copy_cnt_reg, copy_cnt_next;

    // result held while the memory read completes
    kind_t              res_kind_reg, res_kind_next;
    logic [INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic [INFO_W-1:0]  res_info_reg, res_info_next;
    logic               res_pend_reg, res_pend_next;
    logic               res_bend_reg, res_bend_next;
    logic [SRC_W-1:0]   res_src_reg, res_src_next;
    logic               res_stg_reg, res_stg_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [WORD_W-1:0]  m_data_reg, m_data_next;
    logic [INDEX_W-1:0] m_idx_reg, m_idx_next;
    logic [INFO_W-1:0]  m_info_reg, m_info_next;
    logic               m_last_reg, m_last_next;
    logic               m_bend_reg, m_bend_next;
    logic [SRC_W-1:0]   m_src_reg, m_src_next;

    // memory ports
    logic                   stg_we, stg_re;
    logic [STG_ADDR_W-1:0]  stg_waddr, stg_raddr;
    logic [WORD_W-1:0]      stg_rdata;
    logic                   slot_we, slot_re;
    logic [SLOT_ADDR_W-1:0] slot_waddr, slot_raddr;
    logic [WORD_W-1:0]      slot_wdata, slot_rdata;

    // capture decode
    logic                  accept;
    logic                  cfg_write;
    logic                  is_ctrl, id_clear, id_in_range, capture;
    logic [7:0]            id_slot;
    slot_idx_t             cap_slot;
    logic [SLOT_COUNT-1:0] valid_after;
    logic                  tick_last;

    tscr_ram #(.WIDTH(WORD_W), .DEPTH(PACKET_WORDS)) u_staging_ram (
        .aclk  (aclk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (s_tdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    tscr_ram #(.WIDTH(WORD_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {(M_TDATA_W - 51)'(0), m_src_reg, m_bend_reg, m_info_reg,
                       m_idx_reg, m_data_reg};

    // APB read back
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_OUTPUT_ENABLE: prdata = {31'd0, output_enable_reg};
            REG_REPLAY_ENABLE: prdata = {31'd0, replay_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Control packet check on the latched header and table id
    assign is_ctrl     = (hdr_reg == CTRL_SYNC);
    assign id_clear    = (id_reg == ID_CLEAR);
    assign id_slot     = id_reg - ID_FIRST;
    assign id_in_range = (id_reg >= ID_FIRST) && (id_reg < ID_END)
                         && (32'(id_slot) < SLOT_COUNT);
    assign capture     = is_ctrl && (id_clear || id_in_range);
    assign cap_slot    = id_clear ? '0 : SLOT_IDX_W'(id_slot);
    assign tick_last   = (replay_word_reg == INDEX_W'(PACKET_WORDS - 1));

    always_comb begin
        state_next          = state_reg;
        output_enable_next  = output_enable_reg;
        replay_enable_next  = replay_enable_reg;
        load_count_next     = load_count_reg;
        hdr_next            = hdr_reg;
        id_next             = id_reg;
        staging_info_next   = staging_info_reg;
        slot_valid_next     = slot_valid_reg;
        slot_info_next      = slot_info_reg;
        replay_pending_next = replay_pending_reg;
        replay_slot_next    = replay_slot_reg;
        replay_word_next    = replay_word_reg;
        copy_needed_next    = copy_needed_reg;
        copy_base_next      = copy_base_reg;
        copy_cnt_next       = copy_cnt_reg;
        res_kind_next       = res_kind_reg;
        res_idx_next        = res_idx_reg;
        res_info_next       = res_info_reg;
        res_pend_next       = res_pend_reg;
        res_bend_next       = res_bend_reg;
        res_src_next        = res_src_reg;
        res_stg_next        = res_stg_reg;
        m_valid_next        = m_valid_reg && !m_tready;
        m_kind_next         = m_kind_reg;
        m_data_next         = m_data_reg;
        m_idx_next          = m_idx_reg;
        m_info_next         = m_info_reg;
        m_last_next         = m_last_reg;
        m_bend_next         = m_bend_reg;
        m_src_next          = m_src_reg;
        stg_we     = 1'b0;
        stg_waddr  = load_count_reg[STG_ADDR_W-1:0];
        stg_re     = 1'b0;
        stg_raddr  = replay_word_reg[STG_ADDR_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = copy_base_reg;
        slot_wdata = stg_rdata;
        slot_re    = 1'b0;
        slot_raddr = slot_base(replay_slot_reg) + SLOT_ADDR_W'(replay_word_reg);
        valid_after = slot_valid_reg;

        // register writes
        if (cfg_write) begin
            case (paddr[2])
                REG_OUTPUT_ENABLE: output_enable_next = pwdata[0];
                REG_REPLAY_ENABLE: replay_enable_next = pwdata[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next    = ST_RESP;
                    res_kind_next = KIND_IDLE;
                    res_idx_next  = '0;
                    res_info_next = '0;
                    res_pend_next = 1'b0;
                    res_bend_next = 1'b0;
                    res_src_next  = '0;
                    res_stg_next  = 1'b0;
                    if (s_tuser == OP_LOAD) begin
                        if (replay_pending_reg) begin
                            res_kind_next = KIND_REFUSED;
                        end else if (load_count_reg < WORD_CNT_W'(PACKET_WORDS)) begin
                            // packet word into staging
                            res_kind_next   = KIND_ACCEPTED;
                            stg_we          = 1'b1;
                            load_count_next = load_count_reg + 1'b1;
                            if (load_count_reg == '0) begin
                                hdr_next = s_tdata[31:8];
                            end
                            if (load_count_reg == WORD_CNT_W'(1)) begin
                                id_next = s_tdata[23:16];
                            end
                        end else begin
                            // info word: packet complete
                            res_kind_next     = KIND_ACCEPTED;
                            staging_info_next = s_tdata[INFO_W-1:0];
                            load_count_next   = '0;
                            if (capture) begin
                                if (id_clear) begin
                                    valid_after = '0;
                                end
                                valid_after[cap_slot[SLOT_SEL_W-1:0]] = 1'b1;
                                slot_info_next[cap_slot[SLOT_SEL_W-1:0]] =
                                    s_tdata[INFO_W-1:0];
                                copy_needed_next = 1'b1;
                                copy_base_next   = slot_base(cap_slot);
                            end
                            slot_valid_next = valid_after;
                            if (output_enable_reg) begin
                                replay_pending_next = 1'b1;
                                replay_word_next    = '0;
                                replay_slot_next    = replay_enable_reg
                                                      ? first_valid(valid_after, '0)
                                                      : NEW_SLOT;
                            end
                        end
                    end else if (!replay_pending_reg) begin
                        res_kind_next = KIND_IDLE;
                    end else begin
                        // output tick: fetch one word of the burst
                        res_kind_next = KIND_DATA;
                        res_idx_next  = replay_word_reg;
                        res_src_next  = SRC_W'(replay_slot_reg);
                        res_stg_next  = (replay_slot_reg >= NEW_SLOT);
                        if (replay_slot_reg < NEW_SLOT) begin
                            slot_re = 1'b1;
                        end else begin
                            stg_re = 1'b1;
                        end
                        if (tick_last) begin
                            res_pend_next    = 1'b1;
                            res_info_next    = (replay_slot_reg < NEW_SLOT)
                                ? slot_info_reg[replay_slot_reg[SLOT_SEL_W-1:0]]
                                : staging_info_reg;
                            replay_word_next = '0;
                            if (replay_slot_reg >= NEW_SLOT) begin
                                res_bend_next       = 1'b1;
                                replay_pending_next = 1'b0;
                                replay_slot_next    = '0;
                            end else begin
                                replay_slot_next = first_valid(slot_valid_reg,
                                                               replay_slot_reg + 1'b1);
                            end
                        end else begin
                            replay_word_next = replay_word_reg + 1'b1;
                        end
                    end
                end
            end

            ST_RESP: begin
                // read data is in; move result to the output register
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_data_next   = (res_kind_reg != KIND_DATA) ? '0
                                    : (res_stg_reg ? stg_rdata : slot_rdata);
                    m_idx_next    = res_idx_reg;
                    m_info_next   = res_info_reg;
                    m_last_next   = res_pend_reg;
                    m_bend_next   = res_bend_reg;
                    m_src_next    = res_src_reg;
                    copy_cnt_next = '0;
                    state_next    = copy_needed_reg ? ST_COPY : ST_IDLE;
                end
            end

            ST_COPY: begin
                // read staging word k, write slot word k-1
                if (copy_cnt_reg < WORD_CNT_W'(PACKET_WORDS)) begin
                    stg_re    = 1'b1;
                    stg_raddr = copy_cnt_reg[STG_ADDR_W-1:0];
                end
                if (copy_cnt_reg != '0) begin
                    slot_we    = 1'b1;
                    slot_waddr = copy_base_reg + SLOT_ADDR_W'(copy_cnt_reg - 1'b1);
                end
                copy_cnt_next = copy_cnt_reg + 1'b1;
                if (copy_cnt_reg == WORD_CNT_W'(PACKET_WORDS)) begin
                    copy_needed_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            output_enable_reg  <= 1'b1;
            replay_enable_reg  <= 1'b0;
            load_count_reg     <= '0;
            staging_info_reg   <= '0;
            slot_valid_reg     <= '0;
            replay_pending_reg <= 1'b0;
            replay_slot_reg    <= '0;
            replay_word_reg    <= '0;
            copy_needed_reg    <= 1'b0;
            copy_cnt_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            output_enable_reg  <= output_enable_next;
            replay_enable_reg  <= replay_enable_next;
            load_count_reg     <= load_count_next;
            staging_info_reg   <= staging_info_next;
            slot_valid_reg     <= slot_valid_next;
            replay_pending_reg <= replay_pending_next;
            replay_slot_reg    <= replay_slot_next;
            replay_word_reg    <= replay_word_next;
            copy_needed_reg    <= copy_needed_next;
            copy_cnt_reg       <= copy_cnt_next;
            m_valid_reg        <= m_valid_next;
            hdr_reg            <= hdr_next;
            id_reg             <= id_next;
            slot_info_reg      <= slot_info_next;
            copy_base_reg      <= copy_base_next;
            res_kind_reg       <= res_kind_next;
            res_idx_reg        <= res_idx_next;
            res_info_reg       <= res_info_next;
            res_pend_reg       <= res_pend_next;
            res_bend_reg       <= res_bend_next;
            res_src_reg        <= res_src_next;
            res_stg_reg        <= res_stg_next;
            m_kind_reg         <= m_kind_next;
            m_data_reg         <= m_data_next;
            m_idx_reg          <= m_idx_next;
            m_info_reg         <= m_info_next;
            m_last_reg         <= m_last_next;
            m_bend_reg         <= m_bend_next;
            m_src_reg          <= m_src_next;
        end
    end

    // a pending burst only points at a slot that holds a packet
    a_replay_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (replay_pending_reg && (replay_slot_reg < NEW_SLOT))
            |-> slot_valid_reg[replay_slot_reg[SLOT_SEL_W-1:0]])
        else $error("replay points at an empty slot");

    // word position stays inside the packet
    a_word_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (replay_word_reg <= INDEX_W'(PACKET_WORDS - 1))
            && (load_count_reg <= WORD_CNT_W'(PACKET_WORDS)))
        else $error("word counter out of range");

    // each accepted item is answered from the response state
    a_accept_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_RESP))
        else $error("accepted item not followed by response");

    // the burst ends only on the last word of the new packet
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bend_reg)
            |-> (m_last_reg && (m_src_reg == SRC_W'(NEW_SLOT)) && (m_kind_reg == KIND_DATA)))
        else $error("burst end on a wrong word");

    // the slot copy never overlaps a slot-memory replay fetch or a staging write
    a_copy_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (!slot_re && !stg_we))
        else $error("memory access during slot copy");

endmodule
